// ===== hw/rtl/stt_pkg.sv =====
// Shared types, token codes and character tables for the source text tokenizer.
package stt_pkg;

    // scanner modes
    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_CHAR_OPEN, M_CHAR_GOT,
        M_COMMENT, M_OPERATOR, M_DONE, M_HALT
    } t_mode;

    // one result beat
    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [15:0] length;
        logic [59:0] value;
        logic [1:0]  ltype;
        logic [2:0]  err;
        logic        last;
    } t_tok;

    // token kinds
    localparam logic [5:0] KIND_EOF    = 6'd0;
    localparam logic [5:0] KIND_NUMBER = 6'd1;
    localparam logic [5:0] KIND_STRING = 6'd2;
    localparam logic [5:0] KIND_IDENT  = 6'd3;
    localparam logic [5:0] KIND_KW     = 6'd4;
    localparam logic [5:0] KIND_SINGLE = 6'd17;
    localparam logic [5:0] KIND_PAIR   = 6'd30;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
    localparam logic [2:0] ERR_UNTERM   = 3'd2;
    localparam logic [2:0] ERR_BADCHAR  = 3'd3;
    localparam logic [2:0] ERR_UNCLOSED = 3'd4;
    localparam logic [2:0] ERR_IDLONG   = 3'd5;
    localparam logic [2:0] ERR_NUMLONG  = 3'd6;

    // literal types
    localparam logic [1:0] LT_NONE = 2'd0;
    localparam logic [1:0] LT_CHAR = 2'd1;
    localparam logic [1:0] LT_INT  = 2'd2;
    localparam logic [1:0] LT_LONG = 2'd3;

    localparam int NUM_KW       = 13;
    localparam int PREFIX_DEPTH = 6;
    localparam int NUM_SINGLE   = 13;
    localparam int NUM_PAIR     = 6;

    localparam logic [7:0] KW_TEXT [NUM_KW][PREFIX_DEPTH] = '{
        '{"p", "r", "o", "c", 8'h00, 8'h00},
        '{"l", "e", "t", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"e", "l", "s", "i", "f", 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"t", "a", "b", "l", "e", 8'h00},
        '{"r", "e", "t", "u", "r", "n"},
        '{"v", "o", "i", "d", 8'h00, 8'h00},
        '{"c", "h", "a", "r", 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"l", "o", "n", "g", 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd4, 3'd3, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5, 3'd5, 3'd6, 3'd4, 3'd4, 3'd3, 3'd4
    };
    localparam logic [7:0] SINGLE_CHARS [NUM_SINGLE] = '{
        "+", "-", "*", "/", "(", ")", "{", "}", "[", "]", ";", ",", ":"
    };
    localparam logic [7:0] PAIR_FIRST  [NUM_PAIR] = '{"<", ">", "!", "=", "|", "&"};
    localparam logic [7:0] PAIR_SECOND [NUM_PAIR] = '{"=", "=", "=", "=", "|", "&"};

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

endpackage

// ===== hw/rtl/stt_if.sv =====
// Stream interfaces for source bytes and token results.
interface stt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    modport source (output valid, output source_byte, input ready);
    modport sink   (input valid, input source_byte, output ready);
endinterface

interface stt_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic [59:0] literal_value;
    logic [1:0]  literal_type;
    logic [2:0]  error_code;
    logic        last_of_item;
    modport source (output valid, output token_kind, output token_start,
                    output token_length, output literal_value, output literal_type,
                    output error_code, output last_of_item, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input literal_value, input literal_type,
                    input error_code, input last_of_item, output ready);
endinterface

// ===== hw/rtl/stt_scan.sv =====
// Scanner state and per-byte token logic; yields up to two results per byte.
module stt_scan #(
    parameter int IDENT_LIMIT       = 32,
    parameter int NUMBER_CHAR_LIMIT = 18
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic [7:0]     i_byte,
    output logic [1:0]     o_count,
    output stt_pkg::t_tok  o_tok0,
    output stt_pkg::t_tok  o_tok1
);

    stt_pkg::t_mode r_mode, n_mode;
    logic [31:0] r_off, n_off;
    logic [31:0] r_origin, n_origin;
    logic [15:0] r_run, n_run;
    logic [59:0] r_acc, n_acc;
    logic [7:0]  r_held, n_held;
    logic [7:0]  r_prefix [stt_pkg::PREFIX_DEPTH];
    logic        pfx_we;
    logic [2:0]  pfx_addr;

    // character classes of the incoming byte
    logic is_digit, is_head, is_space;
    logic       single_hit, pair_hit, held_hit;
    logic [3:0] single_idx;
    logic [2:0] pair_idx, held_idx;

    always_comb begin
        is_digit = (i_byte >= "0") && (i_byte <= "9");
        is_head  = ((i_byte >= "a") && (i_byte <= "z")) ||
                   ((i_byte >= "A") && (i_byte <= "Z")) || (i_byte == "_");
        is_space = (i_byte == stt_pkg::CH_TAB) || (i_byte == stt_pkg::CH_CR) ||
                   (i_byte == stt_pkg::CH_SPACE) || (i_byte == stt_pkg::CH_LF);
        single_hit = 1'b0;
        single_idx = '0;
        for (int i = 0; i < stt_pkg::NUM_SINGLE; i++) begin
            if (i_byte == stt_pkg::SINGLE_CHARS[i]) begin
                single_hit = 1'b1;
                single_idx = 4'(i);
            end
        end
        pair_hit = 1'b0;
        pair_idx = '0;
        held_hit = 1'b0;
        held_idx = '0;
        for (int i = stt_pkg::NUM_PAIR - 1; i >= 0; i--) begin
            if (i_byte == stt_pkg::PAIR_FIRST[i]) begin
                pair_hit = 1'b1;
                pair_idx = 3'(i);
            end
            if (r_held == stt_pkg::PAIR_FIRST[i]) begin
                held_hit = 1'b1;
                held_idx = 3'(i);
            end
        end
    end

    // keyword lookup, exact length and text
    logic [5:0] word_kind;
    always_comb begin
        logic same;
        word_kind = stt_pkg::KIND_IDENT;
        for (int k = stt_pkg::NUM_KW - 1; k >= 0; k--) begin
            same = (r_run == 16'(stt_pkg::KW_LEN[k]));
            for (int i = 0; i < stt_pkg::PREFIX_DEPTH; i++) begin
                if ((3'(i) < stt_pkg::KW_LEN[k]) && (r_prefix[i] != stt_pkg::KW_TEXT[k][i]))
                    same = 1'b0;
            end
            if (same) word_kind = 6'(stt_pkg::KIND_KW + 6'(k));
        end
    end

    // dispatch of a byte from the idle mode
    stt_pkg::t_mode d_mode;
    logic           d_emit, d_setrun, d_pfx;
    stt_pkg::t_tok  d_tok;
    logic [15:0]    d_run;

    always_comb begin
        d_mode   = stt_pkg::M_IDLE;
        d_emit   = 1'b0;
        d_setrun = 1'b0;
        d_pfx    = 1'b0;
        d_run    = 16'd1;
        d_tok    = '0;
        d_tok.start = r_off;
        if (i_byte == stt_pkg::CH_NUL) begin
            d_mode = stt_pkg::M_DONE;
            d_emit = 1'b1;
        end else if (is_space) begin
            d_mode = stt_pkg::M_IDLE;
        end else if (i_byte == "#") begin
            d_mode = stt_pkg::M_COMMENT;
        end else if (single_hit) begin
            d_emit = 1'b1;
            d_tok.kind   = 6'(stt_pkg::KIND_SINGLE + 6'(single_idx));
            d_tok.length = 16'd1;
        end else if (pair_hit) begin
            d_mode = stt_pkg::M_OPERATOR;
        end else if (i_byte == "'") begin
            d_mode = stt_pkg::M_CHAR_OPEN;
        end else if (i_byte == "\"") begin
            d_mode   = stt_pkg::M_STRING;
            d_setrun = 1'b1;
        end else if (is_digit) begin
            d_mode   = stt_pkg::M_NUMBER;
            d_setrun = 1'b1;
        end else if (is_head) begin
            d_mode   = stt_pkg::M_IDENT;
            d_setrun = 1'b1;
            d_pfx    = 1'b1;
        end else begin
            d_mode = stt_pkg::M_HALT;
            d_emit = 1'b1;
            d_tok.err = stt_pkg::ERR_UNKNOWN;
        end
    end

    // per-byte step
    stt_pkg::t_tok toks [2];
    logic [1:0]    cnt;

    always_comb begin
        logic          dsp;
        logic          push;
        stt_pkg::t_tok pt;
        logic [59:0]   acc10;
        logic [5:0]    pbase;
        n_mode   = r_mode;
        n_off    = r_off;
        n_origin = r_origin;
        n_run    = r_run;
        n_acc    = r_acc;
        n_held   = r_held;
        pfx_we   = 1'b0;
        pfx_addr = r_run[2:0];
        toks[0]  = '0;
        toks[1]  = '0;
        cnt      = 2'd0;
        dsp      = 1'b0;
        push     = 1'b0;
        pt       = '0;
        pt.start = r_origin;
        acc10    = (r_acc << 3) + (r_acc << 1) + 60'(i_byte - "0");
        pbase    = 6'(stt_pkg::KIND_PAIR + {2'b00, (held_hit ? held_idx : 3'd0), 1'b0});
        if ((r_mode != stt_pkg::M_DONE) && (r_mode != stt_pkg::M_HALT)) begin
            n_off = r_off + 32'd1;
        end
        case (r_mode)
            stt_pkg::M_DONE, stt_pkg::M_HALT: begin
            end
            stt_pkg::M_IDENT: begin
                if (is_head || is_digit) begin
                    if (r_run >= 16'(IDENT_LIMIT)) begin
                        push = 1'b1;
                        pt.err = stt_pkg::ERR_IDLONG;
                        n_mode = stt_pkg::M_HALT;
                    end else begin
                        pfx_we = (r_run < 16'(stt_pkg::PREFIX_DEPTH));
                        n_run  = r_run + 16'd1;
                    end
                end else begin
                    push = 1'b1;
                    pt.kind   = word_kind;
                    pt.length = r_run;
                    dsp = 1'b1;
                end
            end
            stt_pkg::M_NUMBER: begin
                if (is_digit || (i_byte == "L") || (i_byte == "B") || (i_byte == "I")) begin
                    if (r_run >= 16'(NUMBER_CHAR_LIMIT)) begin
                        push = 1'b1;
                        pt.err = stt_pkg::ERR_NUMLONG;
                        n_mode = stt_pkg::M_HALT;
                    end else if (is_digit) begin
                        n_acc = acc10;
                        n_run = r_run + 16'd1;
                    end else begin
                        push = 1'b1;
                        pt.kind   = stt_pkg::KIND_NUMBER;
                        pt.length = r_run + 16'd1;
                        pt.value  = r_acc;
                        pt.ltype  = (i_byte == "L") ? stt_pkg::LT_LONG :
                                    (i_byte == "B") ? stt_pkg::LT_CHAR : stt_pkg::LT_INT;
                        n_mode = stt_pkg::M_IDLE;
                    end
                end else begin
                    push = 1'b1;
                    pt.kind   = stt_pkg::KIND_NUMBER;
                    pt.length = r_run;
                    pt.value  = r_acc;
                    dsp = 1'b1;
                end
            end
            stt_pkg::M_STRING: begin
                if (i_byte == "\"") begin
                    push = 1'b1;
                    pt.kind   = stt_pkg::KIND_STRING;
                    pt.length = (r_run == 16'hFFFF) ? 16'hFFFF : r_run + 16'd1;
                    n_mode = stt_pkg::M_IDLE;
                end else if (i_byte == stt_pkg::CH_NUL) begin
                    push = 1'b1;
                    pt.err = stt_pkg::ERR_UNTERM;
                    n_mode = stt_pkg::M_HALT;
                end else if (r_run != 16'hFFFF) begin
                    n_run = r_run + 16'd1;
                end
            end
            stt_pkg::M_CHAR_OPEN: begin
                if (i_byte == stt_pkg::CH_NUL) begin
                    push = 1'b1;
                    pt.err = stt_pkg::ERR_UNCLOSED;
                    n_mode = stt_pkg::M_HALT;
                end else if (i_byte[7]) begin
                    push = 1'b1;
                    pt.err = stt_pkg::ERR_BADCHAR;
                    n_mode = stt_pkg::M_HALT;
                end else begin
                    n_held = i_byte;
                    n_mode = stt_pkg::M_CHAR_GOT;
                end
            end
            stt_pkg::M_CHAR_GOT: begin
                push = 1'b1;
                if (i_byte == "'") begin
                    pt.kind   = stt_pkg::KIND_NUMBER;
                    pt.length = 16'd3;
                    pt.value  = 60'(r_held);
                    pt.ltype  = stt_pkg::LT_CHAR;
                    n_mode = stt_pkg::M_IDLE;
                end else begin
                    pt.err = stt_pkg::ERR_UNCLOSED;
                    n_mode = stt_pkg::M_HALT;
                end
            end
            stt_pkg::M_COMMENT: begin
                if (i_byte == stt_pkg::CH_LF) n_mode = stt_pkg::M_IDLE;
                else if (i_byte == stt_pkg::CH_NUL) dsp = 1'b1;
            end
            stt_pkg::M_OPERATOR: begin
                push = 1'b1;
                pt.length = 16'd1;
                pt.kind   = pbase;
                if (i_byte == stt_pkg::PAIR_SECOND[held_hit ? held_idx : 3'd0]) begin
                    pt.kind   = pbase + 6'd1;
                    pt.length = 16'd2;
                    n_mode = stt_pkg::M_IDLE;
                end else begin
                    dsp = 1'b1;
                end
            end
            default: begin
                dsp = 1'b1;
            end
        endcase

        if (push) begin
            toks[0] = pt;
            cnt = 2'd1;
        end
        if (dsp) begin
            n_mode   = d_mode;
            n_origin = r_off;
            if (d_mode == stt_pkg::M_OPERATOR) n_held = i_byte;
            if (d_setrun) n_run = d_run;
            if (i_byte[7:4] == 4'h3) n_acc = 60'(i_byte - "0");
            if (d_pfx) begin
                pfx_we   = 1'b1;
                pfx_addr = 3'd0;
            end
            if (d_emit) begin
                toks[cnt[0]] = d_tok;
                cnt = cnt + 2'd1;
            end
        end
        if (cnt == 2'd1) toks[0].last = 1'b1;
        if (cnt == 2'd2) toks[1].last = 1'b1;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= stt_pkg::M_IDLE;
            r_off    <= '0;
            r_origin <= '0;
            r_run    <= '0;
            r_acc    <= '0;
            r_held   <= '0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_off    <= n_off;
            r_origin <= n_origin;
            r_run    <= n_run;
            r_acc    <= n_acc;
            r_held   <= n_held;
        end
    end

    // identifier prefix store
    always_ff @(posedge i_clk) begin
        if (i_take && pfx_we) r_prefix[pfx_addr] <= i_byte;
    end

    assign o_count = i_take ? cnt : 2'd0;
    assign o_tok0  = toks[0];
    assign o_tok1  = toks[1];

`ifndef NO_ASSERTIONS
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == stt_pkg::M_HALT) |=> (r_mode == stt_pkg::M_HALT))
        else $error("halt mode left before reset");
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == stt_pkg::M_DONE) |-> (o_count == 2'd0))
        else $error("result after end of source");
    a_off_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == stt_pkg::M_DONE || r_mode == stt_pkg::M_HALT) |=> $stable(r_off))
        else $error("offset moved after end");
`endif

endmodule

// ===== hw/rtl/stt_fifo.sv =====
// Four-entry result queue; takes up to two results a cycle, gives one.
module stt_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_push,
    input  stt_pkg::t_tok  i_tok0,
    input  stt_pkg::t_tok  i_tok1,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_pop,
    output stt_pkg::t_tok  o_tok
);

    stt_pkg::t_tok r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_count;
    logic       pop;

    assign pop     = i_pop && (r_count != 3'd0);
    assign o_room  = (r_count <= 3'd2);
    assign o_valid = (r_count != 3'd0);
    assign o_tok   = r_mem[r_rp];

    // entry writes
    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) r_mem[r_wp] <= i_tok0;
        if (i_push == 2'd2) r_mem[r_wp + 2'd1] <= i_tok1;
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + i_push;
            r_rp    <= r_rp + {1'b0, pop};
            r_count <= r_count + {1'b0, i_push} - {2'b00, pop};
        end
    end

`ifndef NO_ASSERTIONS
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("queue overfilled");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push != 2'd0) |-> o_room)
        else $error("push without room");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push == 2'd0 && pop) |=> (r_count == $past(r_count) - 3'd1))
        else $error("pop miscounted");
`endif

endmodule

// ===== hw/rtl/source_text_tokenizer.sv =====
// Top level of the streaming source text tokenizer.
//  channel  dir  beat
//  i_src    in   source_byte, one source character; 0 ends the source
//  o_tok    out  one token or error result, last_of_item marks a byte's last
// One byte is taken per cycle while the result queue has room for two beats.
// The scanner settles each byte combinationally; results wait in a four-entry queue.
// A stall on o_tok backs up into i_src once fewer than two slots are free.
// Synchronous active-low reset clears the scanner and the queue.
module source_text_tokenizer #(
    parameter int IDENT_LIMIT       = 32,
    parameter int NUMBER_CHAR_LIMIT = 18
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stt_byte_if.sink      i_src,
    stt_tok_if.source     o_tok
);

    logic          room, take;
    logic [1:0]    count;
    stt_pkg::t_tok tok0, tok1, head;

    assign i_src.ready = room;
    assign take        = i_src.valid && room;

    stt_scan #(
        .IDENT_LIMIT       (IDENT_LIMIT),
        .NUMBER_CHAR_LIMIT (NUMBER_CHAR_LIMIT)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_src.source_byte),
        .o_count (count),
        .o_tok0  (tok0),
        .o_tok1  (tok1)
    );

    stt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (count),
        .i_tok0  (tok0),
        .i_tok1  (tok1),
        .o_room  (room),
        .o_valid (o_tok.valid),
        .i_pop   (o_tok.ready),
        .o_tok   (head)
    );

    // result fields
    assign o_tok.token_kind    = head.kind;
    assign o_tok.token_start   = head.start;
    assign o_tok.token_length  = head.length;
    assign o_tok.literal_value = head.value;
    assign o_tok.literal_type  = head.ltype;
    assign o_tok.error_code    = head.err;
    assign o_tok.last_of_item  = head.last;

endmodule

// ===== test/source_text_tokenizer_tb.sv =====
// Self-checking testbench for the source text tokenizer: one long scripted source, predicted.
`timescale 1ns / 1ps

module source_text_tokenizer_tb;

    localparam int IDENT_LIMIT       = 32;
    localparam int NUMBER_CHAR_LIMIT = 18;
    localparam int RANDOM_BYTES      = 1270;
    localparam int CYCLE_LIMIT       = 100000;

    // one directed row: a source byte, plus an expected kind where obvious
    typedef struct {
        logic [7:0] ch;
        bit         chk;
        logic [5:0] kind;
        logic [2:0] err;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    stt_byte_if src_if ();
    stt_tok_if  tok_if ();

    source_text_tokenizer #(
        .IDENT_LIMIT       (IDENT_LIMIT),
        .NUMBER_CHAR_LIMIT (NUMBER_CHAR_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_if.source),
        .o_tok   (tok_if.sink)
    );

    // clock and cycle guard
    int cycles = 0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    int            mismatches = 0;
    stt_pkg::t_tok expected_tokens[$];
    logic [7:0]    source_text[$];
    t_row          directed_rows[$];

    task automatic report(input string what);
        $display("mismatch @%0d: %s", cycles, what);
        mismatches++;
    endtask

    // ---------------- scanner model ----------------
    stt_pkg::t_mode sc_mode   = stt_pkg::M_IDLE;
    logic [31:0]    sc_offset = '0;
    logic [31:0]    sc_origin = '0;
    logic [15:0]    sc_run    = '0;
    logic [59:0]    sc_acc    = '0;
    logic [7:0]     sc_prefix [stt_pkg::PREFIX_DEPTH];
    logic [7:0]     sc_held   = '0;
    int             sc_emitted;

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_head(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic int pair_slot(logic [7:0] b);
        for (int i = 0; i < stt_pkg::NUM_PAIR; i++)
            if (stt_pkg::PAIR_FIRST[i] == b) return i;
        return -1;
    endfunction

    function automatic logic [5:0] word_kind();
        bit same;
        for (int k = 0; k < stt_pkg::NUM_KW; k++) begin
            if (stt_pkg::KW_LEN[k] != sc_run) continue;
            same = 1'b1;
            for (int i = 0; i < stt_pkg::KW_LEN[k]; i++)
                if (sc_prefix[i] != stt_pkg::KW_TEXT[k][i]) same = 1'b0;
            if (same) return stt_pkg::KIND_KW + 6'(k);
        end
        return stt_pkg::KIND_IDENT;
    endfunction

    task automatic emit(input logic [5:0] kind, input logic [31:0] start,
                        input logic [15:0] len, input logic [59:0] val,
                        input logic [1:0] lt, input logic [2:0] err);
        stt_pkg::t_tok t;
        t = '{kind: kind, start: start, length: len, value: val, ltype: lt,
              err: err, last: 1'b0};
        expected_tokens.push_back(t);
        sc_emitted++;
    endtask

    task automatic halt_with(input logic [31:0] start, input logic [2:0] err);
        sc_mode = stt_pkg::M_HALT;
        emit(stt_pkg::KIND_EOF, start, 0, 0, stt_pkg::LT_NONE, err);
    endtask

    // a byte seen with no token open
    task automatic open_token(input logic [7:0] b, input logic [31:0] off);
        sc_mode = stt_pkg::M_IDLE;
        sc_origin = off;
        if (b == stt_pkg::CH_NUL) begin
            sc_mode = stt_pkg::M_DONE;
            emit(stt_pkg::KIND_EOF, off, 0, 0, stt_pkg::LT_NONE, stt_pkg::ERR_NONE);
            return;
        end
        if (b == stt_pkg::CH_TAB || b == stt_pkg::CH_CR || b == stt_pkg::CH_SPACE ||
            b == stt_pkg::CH_LF) return;
        if (b == "#") begin sc_mode = stt_pkg::M_COMMENT; return; end
        for (int i = 0; i < stt_pkg::NUM_SINGLE; i++)
            if (stt_pkg::SINGLE_CHARS[i] == b) begin
                emit(stt_pkg::KIND_SINGLE + 6'(i), off, 1, 0, stt_pkg::LT_NONE,
                     stt_pkg::ERR_NONE);
                return;
            end
        if (pair_slot(b) >= 0) begin
            sc_held = b;
            sc_mode = stt_pkg::M_OPERATOR;
            return;
        end
        if (b == "'") begin sc_mode = stt_pkg::M_CHAR_OPEN; return; end
        if (b == "\"") begin sc_mode = stt_pkg::M_STRING; sc_run = 1; return; end
        if (is_digit(b)) begin
            sc_mode = stt_pkg::M_NUMBER;
            sc_acc = 60'(b - "0");
            sc_run = 1;
            return;
        end
        if (is_head(b)) begin
            sc_mode = stt_pkg::M_IDENT;
            sc_prefix[0] = b;
            sc_run = 1;
            return;
        end
        halt_with(off, stt_pkg::ERR_UNKNOWN);
    endtask

    // predict the results of one accepted byte
    task automatic scan_byte(input logic [7:0] b);
        logic [31:0] off;
        int p;
        logic [5:0] base;
        logic [1:0] lt;
        sc_emitted = 0;
        if (sc_mode == stt_pkg::M_DONE || sc_mode == stt_pkg::M_HALT) return;
        off = sc_offset;
        sc_offset = off + 1;
        case (sc_mode)
            stt_pkg::M_IDENT: begin
                if (is_head(b) || is_digit(b)) begin
                    if (sc_run >= IDENT_LIMIT) halt_with(sc_origin, stt_pkg::ERR_IDLONG);
                    else begin
                        if (sc_run < stt_pkg::PREFIX_DEPTH) sc_prefix[sc_run] = b;
                        sc_run++;
                    end
                end else begin
                    emit(word_kind(), sc_origin, sc_run, 0, stt_pkg::LT_NONE,
                         stt_pkg::ERR_NONE);
                    open_token(b, off);
                end
            end
            stt_pkg::M_NUMBER: begin
                if (is_digit(b)) begin
                    if (sc_run >= NUMBER_CHAR_LIMIT)
                        halt_with(sc_origin, stt_pkg::ERR_NUMLONG);
                    else begin
                        sc_acc = sc_acc * 10 + 60'(b - "0");
                        sc_run++;
                    end
                end else if (b == "L" || b == "B" || b == "I") begin
                    if (sc_run >= NUMBER_CHAR_LIMIT)
                        halt_with(sc_origin, stt_pkg::ERR_NUMLONG);
                    else begin
                        lt = (b == "L") ? stt_pkg::LT_LONG :
                             (b == "B") ? stt_pkg::LT_CHAR : stt_pkg::LT_INT;
                        emit(stt_pkg::KIND_NUMBER, sc_origin, sc_run + 1, sc_acc, lt,
                             stt_pkg::ERR_NONE);
                        sc_mode = stt_pkg::M_IDLE;
                    end
                end else begin
                    emit(stt_pkg::KIND_NUMBER, sc_origin, sc_run, sc_acc, stt_pkg::LT_NONE,
                         stt_pkg::ERR_NONE);
                    open_token(b, off);
                end
            end
            stt_pkg::M_STRING: begin
                if (b == "\"") begin
                    emit(stt_pkg::KIND_STRING, sc_origin,
                         (sc_run == 16'hFFFF) ? sc_run : sc_run + 1,
                         0, stt_pkg::LT_NONE, stt_pkg::ERR_NONE);
                    sc_mode = stt_pkg::M_IDLE;
                end else if (b == stt_pkg::CH_NUL) halt_with(sc_origin, stt_pkg::ERR_UNTERM);
                else if (sc_run < 16'hFFFF) sc_run++;
            end
            stt_pkg::M_CHAR_OPEN: begin
                if (b == stt_pkg::CH_NUL) halt_with(sc_origin, stt_pkg::ERR_UNCLOSED);
                else if (b >= 8'd128) halt_with(sc_origin, stt_pkg::ERR_BADCHAR);
                else begin
                    sc_held = b;
                    sc_mode = stt_pkg::M_CHAR_GOT;
                end
            end
            stt_pkg::M_CHAR_GOT: begin
                if (b == "'") begin
                    emit(stt_pkg::KIND_NUMBER, sc_origin, 3, 60'(sc_held), stt_pkg::LT_CHAR,
                         stt_pkg::ERR_NONE);
                    sc_mode = stt_pkg::M_IDLE;
                end else halt_with(sc_origin, stt_pkg::ERR_UNCLOSED);
            end
            stt_pkg::M_COMMENT: begin
                if (b == stt_pkg::CH_LF) sc_mode = stt_pkg::M_IDLE;
                else if (b == stt_pkg::CH_NUL) open_token(b, off);
            end
            stt_pkg::M_OPERATOR: begin
                p = pair_slot(sc_held);
                if (p < 0) p = 0;
                base = stt_pkg::KIND_PAIR + 6'(2 * p);
                if (b == stt_pkg::PAIR_SECOND[p]) begin
                    emit(base + 1, sc_origin, 2, 0, stt_pkg::LT_NONE, stt_pkg::ERR_NONE);
                    sc_mode = stt_pkg::M_IDLE;
                end else begin
                    emit(base, sc_origin, 1, 0, stt_pkg::LT_NONE, stt_pkg::ERR_NONE);
                    open_token(b, off);
                end
            end
            default: open_token(b, off);
        endcase
        if (sc_emitted > 0) expected_tokens[$].last = 1'b1;
    endtask

    // ---------------- source generation ----------------
    task automatic add_row(input logic [7:0] ch, input bit chk = 0,
                           input logic [5:0] kind = stt_pkg::KIND_EOF,
                           input logic [2:0] err = stt_pkg::ERR_NONE);
        directed_rows.push_back('{ch: ch, chk: chk, kind: kind, err: err});
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return stt_pkg::CH_TAB;
            1: return stt_pkg::CH_CR;
            2: return stt_pkg::CH_LF;
            default: return stt_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_head();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return "_";
    endfunction

    // append one well-formed token with random content
    task automatic add_random_token();
        int n;
        int k;
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1: begin
                if ($urandom_range(0, 3) == 0) begin
                    k = $urandom_range(0, stt_pkg::NUM_KW - 1);
                    for (int i = 0; i < stt_pkg::KW_LEN[k]; i++)
                        source_text.push_back(stt_pkg::KW_TEXT[k][i]);
                    // sometimes one past the keyword, to miss an exact match
                    if ($urandom_range(0, 2) == 0) source_text.push_back(pick_head());
                end else begin
                    n = ($urandom_range(0, 9) == 0) ? IDENT_LIMIT : $urandom_range(1, 8);
                    source_text.push_back(pick_head());
                    for (int i = 1; i < n; i++)
                        source_text.push_back($urandom_range(0, 3) == 0 ?
                                              8'("0" + $urandom_range(0, 9)) : pick_head());
                end
                source_text.push_back(pick_blank());
            end
            2, 3: begin
                k = $urandom_range(0, 3);
                n = ($urandom_range(0, 7) == 0) ? NUMBER_CHAR_LIMIT - (k != 0)
                                                 : $urandom_range(1, 6);
                for (int i = 0; i < n; i++) source_text.push_back(8'("0" + $urandom_range(0, 9)));
                if (k == 1) source_text.push_back("L");
                if (k == 2) source_text.push_back("B");
                if (k == 3) source_text.push_back("I");
                source_text.push_back(pick_blank());
            end
            4: begin
                source_text.push_back("\"");
                n = $urandom_range(0, 10);
                for (int i = 0; i < n; i++) begin
                    do c = 8'($urandom_range(1, 255)); while (c == "\"");
                    source_text.push_back(c);
                end
                source_text.push_back("\"");
            end
            5: begin
                source_text.push_back("'");
                source_text.push_back(8'($urandom_range(1, 127)));
                source_text.push_back("'");
            end
            6: begin
                source_text.push_back("#");
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++) begin
                    do c = 8'($urandom_range(1, 255)); while (c == stt_pkg::CH_LF);
                    source_text.push_back(c);
                end
                source_text.push_back(stt_pkg::CH_LF);
            end
            7, 8: begin
                if ($urandom_range(0, 1) == 0)
                    source_text.push_back(
                        stt_pkg::SINGLE_CHARS[$urandom_range(0, stt_pkg::NUM_SINGLE - 1)]);
                else begin
                    k = $urandom_range(0, stt_pkg::NUM_PAIR - 1);
                    source_text.push_back(stt_pkg::PAIR_FIRST[k]);
                    if ($urandom_range(0, 1) == 0) source_text.push_back(stt_pkg::PAIR_SECOND[k]);
                end
            end
            default: source_text.push_back(pick_blank());
        endcase
    endtask

    // ---------------- result side ----------------
    int            rx_stall = 0;
    bit            rx_calm  = 0;
    int            rx_beats = 0;
    int            rx_noted = 0;
    stt_pkg::t_tok seen;
    stt_pkg::t_tok want;

    // ready drive: a fresh idle draw after every taken beat
    always @(negedge i_clk) begin
        if (rx_beats != rx_noted) begin
            rx_noted = rx_beats;
            if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
            rx_stall = rx_calm ? 0 : $urandom_range(0, 3);
        end
        if (rx_stall > 0) begin
            tok_if.ready = 1'b0;
            rx_stall--;
        end else tok_if.ready = i_rst_n;
    end

    always @(posedge i_clk) begin
        if (tok_if.valid && tok_if.ready) begin
            seen = '{kind: tok_if.token_kind, start: tok_if.token_start,
                     length: tok_if.token_length, value: tok_if.literal_value,
                     ltype: tok_if.literal_type, err: tok_if.error_code,
                     last: tok_if.last_of_item};
            if (expected_tokens.size() == 0) report($sformatf("unexpected beat %p", seen));
            else begin
                want = expected_tokens.pop_front();
                if (seen !== want) report($sformatf("got %p want %p", seen, want));
            end
            rx_beats++;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        int gap;
        int before_cnt;
        bit tx_calm;
        tx_calm = 0;
        src_if.valid = 1'b0;
        src_if.source_byte = 8'h00;
        foreach (sc_prefix[i]) sc_prefix[i] = '0;

        // directed source
        add_row("i"); add_row("f"); add_row(stt_pkg::CH_SPACE, 1, stt_pkg::KIND_KW + 2);
        add_row("_"); add_row("9"); add_row(";", 1, stt_pkg::KIND_IDENT);
        add_row(">"); add_row("=", 1, stt_pkg::KIND_PAIR + 3);
        add_row("!"); add_row("(", 1, stt_pkg::KIND_PAIR + 4);
        add_row("7"); add_row("B", 1, stt_pkg::KIND_NUMBER);
        add_row("'"); add_row("~"); add_row("'", 1, stt_pkg::KIND_NUMBER);
        add_row("\""); add_row(8'h80); add_row(8'hFF); add_row("\"", 1, stt_pkg::KIND_STRING);
        add_row("#"); add_row(8'h01); add_row(stt_pkg::CH_LF);
        add_row("&"); add_row("&", 1, stt_pkg::KIND_PAIR + 11);
        add_row(stt_pkg::CH_TAB);

        // random source
        while (source_text.size() < RANDOM_BYTES) add_random_token();
        // end of source, or an unknown character, then bytes that are ignored
        source_text.push_back($urandom_range(0, 1) ? stt_pkg::CH_NUL : 8'h80);
        for (int i = 0; i < 3; i++) source_text.push_back(8'($urandom_range(0, 255)));

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < directed_rows.size() + source_text.size(); i++) begin
            // hold off once until the result queue has drained
            if (i == directed_rows.size() + RANDOM_BYTES / 4) begin
                src_if.valid = 1'b0;
                while (expected_tokens.size() != 0) @(negedge i_clk);
            end
            if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
            gap = tx_calm ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                src_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            src_if.valid = 1'b1;
            src_if.source_byte = (i < directed_rows.size()) ? directed_rows[i].ch
                                 : source_text[i - directed_rows.size()];
            do @(posedge i_clk); while (!src_if.ready);
            before_cnt = expected_tokens.size();
            scan_byte(src_if.source_byte);
            if (i < directed_rows.size() && directed_rows[i].chk) begin
                if (expected_tokens.size() == before_cnt ||
                    expected_tokens[before_cnt].kind != directed_rows[i].kind ||
                    expected_tokens[before_cnt].err != directed_rows[i].err)
                    report($sformatf("directed row %0d: kind not %0d", i,
                                     directed_rows[i].kind));
            end
            @(negedge i_clk);
        end
        src_if.valid = 1'b0;

        while (expected_tokens.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/stt_pkg.sv
hw/rtl/stt_if.sv
hw/rtl/stt_scan.sv
hw/rtl/stt_fifo.sv
hw/rtl/source_text_tokenizer.sv
test/source_text_tokenizer_tb.sv
